### rtl/crcfd_pkg.sv
// Shared types, constants and the CRC-32 byte update for the frame decoder.
package crcfd_pkg;

	localparam logic [7:0] HDR_LEN       = 8'd20;
	localparam logic [7:0] CRC_COVER_LEN = 8'd16;
	localparam logic [7:0] MAX_FRAME_LEN = 8'd250;
	localparam logic [7:0] CNT_SAT       = 8'hFF;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	localparam logic [15:0] RST_MAGIC       = 16'h0000;
	localparam logic [7:0]  RST_VERSION     = 8'd1;
	localparam logic [7:0]  RST_RELIABLE    = 8'd1;
	localparam logic [7:0]  RST_ACK         = 8'd2;
	localparam logic [15:0] RST_ACK_ID      = 16'h0000;
	localparam logic [7:0]  RST_MAX_PAYLOAD = 8'd230;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);
	localparam logic [QAW:0] QLIMIT = (QAW + 1)'(QDEPTH - 1);

	typedef enum logic [2:0] {
		CFG_MAGIC,
		CFG_VERSION,
		CFG_RELIABLE,
		CFG_ACK,
		CFG_ACK_ID,
		CFG_MAX_PAYLOAD
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_LENGTH,
		ST_MAGIC,
		ST_VERSION,
		ST_FLAGS,
		ST_LEN_MISMATCH,
		ST_CRC,
		ST_ACK_RULE
	} status_t;

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [15:0] magic;
		logic [7:0]  version;
		logic [7:0]  reliable_mask;
		logic [7:0]  ack_mask;
		logic [15:0] ack_msg_id;
		logic [7:0]  max_payload;
	} cfg_t;

	// one queue entry: an optional payload byte followed by an optional summary
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  data;
		logic        has_sum;
		status_t     status;
		logic [7:0]  flags;
		logic [15:0] msg_id;
		logic [15:0] length;
		logic [31:0] sequence_no;
		logic [31:0] correlation_no;
	} ent_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data_byte;
		logic [2:0]  status;
		logic [7:0]  frame_flags;
		logic [15:0] frame_msg_id;
		logic [15:0] payload_length;
		logic [31:0] sequence_no;
		logic [31:0] correlation_no;
		logic        last_of_run;
	} res_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

endpackage

### rtl/crcfd_if.sv
// Handshake channel interfaces for received frame bytes and decoded results.
interface crcfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       end_of_frame;

	modport source (output valid, output rx_byte, output end_of_frame, input ready);
	modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

interface crcfd_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  data_byte;
	logic [2:0]  status;
	logic [7:0]  frame_flags;
	logic [15:0] frame_msg_id;
	logic [15:0] payload_length;
	logic [31:0] sequence_no;
	logic [31:0] correlation_no;
	logic        last_of_run;

	modport source (output valid, output kind, output data_byte, output status,
		output frame_flags, output frame_msg_id, output payload_length,
		output sequence_no, output correlation_no, output last_of_run, input ready);
	modport sink (input valid, input kind, input data_byte, input status,
		input frame_flags, input frame_msg_id, input payload_length,
		input sequence_no, input correlation_no, input last_of_run, output ready);
endinterface

### rtl/crcfd_parse.sv
// Header capture, running CRC and frame status check, one byte per cycle.
module crcfd_parse #(
	parameter logic [7:0] MAX_FRAME_BYTES = crcfd_pkg::MAX_FRAME_LEN
) (
	input  logic            clk,
	input  logic            arst_n,
	input  crcfd_pkg::cfg_t cfg,
	input  logic            take,
	input  logic [7:0]      take_byte,
	input  logic            take_eof,
	output logic            busy,
	output logic            push,
	output crcfd_pkg::ent_t ent
);
	import crcfd_pkg::*;

	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        eof_s1;

	logic [7:0]  cnt_q,   cnt_n;
	logic [31:0] crc_q,   crc_n;
	logic [15:0] magic_q, magic_n;
	logic [7:0]  ver_q,   ver_n;
	logic [7:0]  flags_q, flags_n;
	logic [15:0] msg_q,   msg_n;
	logic [15:0] len_q,   len_n;
	logic [31:0] seq_q,   seq_n;
	logic [31:0] corr_q,  corr_n;
	logic [31:0] fcs_q,   fcs_n;

	logic [7:0]  idx;
	logic        is_ack;
	logic [16:0] len_total;
	status_t     st;

	assign busy = v_s1;
	assign idx  = cnt_q;

	always_comb begin
		magic_n = magic_q;
		ver_n   = ver_q;
		flags_n = flags_q;
		msg_n   = msg_q;
		len_n   = len_q;
		seq_n   = seq_q;
		corr_n  = corr_q;
		fcs_n   = fcs_q;
		if (idx < 8'd2) begin
			magic_n[8*idx[0] +: 8] = byte_s1;
		end else if (idx == 8'd2) begin
			ver_n = byte_s1;
		end else if (idx == 8'd3) begin
			flags_n = byte_s1;
		end else if (idx < 8'd6) begin
			msg_n[8*idx[0] +: 8] = byte_s1;
		end else if (idx < 8'd8) begin
			len_n[8*idx[0] +: 8] = byte_s1;
		end else if (idx < 8'd12) begin
			seq_n[8*idx[1:0] +: 8] = byte_s1;
		end else if (idx < CRC_COVER_LEN) begin
			corr_n[8*idx[1:0] +: 8] = byte_s1;
		end else if (idx < HDR_LEN) begin
			fcs_n[8*idx[1:0] +: 8] = byte_s1;
		end

		if (idx < CRC_COVER_LEN || idx >= HDR_LEN) begin
			crc_n = crc_byte(crc_q, byte_s1);
		end else begin
			crc_n = crc_q;
		end

		cnt_n = (cnt_q == CNT_SAT) ? cnt_q : cnt_q + 8'd1;
	end

	always_comb begin
		is_ack    = (flags_n & cfg.ack_mask) != 8'h00;
		len_total = {1'b0, len_n} + {9'h0, HDR_LEN};
		if (cnt_n < HDR_LEN || cnt_n > MAX_FRAME_BYTES) begin
			st = ST_LENGTH;
		end else if (magic_n != cfg.magic) begin
			st = ST_MAGIC;
		end else if (ver_n != cfg.version) begin
			st = ST_VERSION;
		end else if ((flags_n & ~(cfg.reliable_mask | cfg.ack_mask)) != 8'h00) begin
			st = ST_FLAGS;
		end else if (len_n > {8'h00, cfg.max_payload} || len_total != {9'h0, cnt_n}) begin
			st = ST_LEN_MISMATCH;
		end else if (fcs_n != ~crc_n) begin
			st = ST_CRC;
		end else if (is_ack && (msg_n != cfg.ack_msg_id || len_n != 16'h0000 ||
				(flags_n & cfg.reliable_mask) != 8'h00 || corr_n == 32'h0)) begin
			st = ST_ACK_RULE;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		ent.has_byte       = idx >= HDR_LEN;
		ent.data           = byte_s1;
		ent.has_sum        = eof_s1;
		ent.status         = st;
		ent.flags          = flags_n;
		ent.msg_id         = msg_n;
		ent.length         = len_n;
		ent.sequence_no    = seq_n;
		ent.correlation_no = corr_n;
		push               = v_s1 && (ent.has_byte || eof_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= take_byte;
			eof_s1  <= take_eof;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= 8'h00;
			crc_q   <= CRC_INIT;
			magic_q <= 16'h0;
			ver_q   <= 8'h00;
			flags_q <= 8'h00;
			msg_q   <= 16'h0;
			len_q   <= 16'h0;
			seq_q   <= 32'h0;
			corr_q  <= 32'h0;
			fcs_q   <= 32'h0;
		end else if (v_s1) begin
			if (eof_s1) begin
				cnt_q   <= 8'h00;
				crc_q   <= CRC_INIT;
				magic_q <= 16'h0;
				ver_q   <= 8'h00;
				flags_q <= 8'h00;
				msg_q   <= 16'h0;
				len_q   <= 16'h0;
				seq_q   <= 32'h0;
				corr_q  <= 32'h0;
				fcs_q   <= 32'h0;
			end else begin
				cnt_q   <= cnt_n;
				crc_q   <= crc_n;
				magic_q <= magic_n;
				ver_q   <= ver_n;
				flags_q <= flags_n;
				msg_q   <= msg_n;
				len_q   <= len_n;
				seq_q   <= seq_n;
				corr_q  <= corr_n;
				fcs_q   <= fcs_n;
			end
		end
	end

endmodule

### rtl/crcfd_outq.sv
// Result queue; each entry is emitted as a payload beat, a summary beat, or both.
module crcfd_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  crcfd_pkg::ent_t        ent,
	input  logic                   res_ready,
	output logic                   res_valid,
	output crcfd_pkg::res_t        res,
	output logic [crcfd_pkg::QAW:0] level
);
	import crcfd_pkg::*;

	ent_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_q;
	logic [QAW-1:0] rd_q;
	logic [QAW:0]   cnt_q;
	logic           phase_q;

	ent_t head;
	logic byte_phase;
	logic fire;
	logic pop;

	assign level      = cnt_q;
	assign head       = mem_q[rd_q];
	assign res_valid  = cnt_q != '0;
	assign byte_phase = head.has_byte && !phase_q;
	assign fire       = res_valid && res_ready;
	assign pop        = fire && (!byte_phase || !head.has_sum);

	always_comb begin
		if (byte_phase) begin
			res.kind           = KIND_DATA;
			res.data_byte      = head.data;
			res.status         = ST_OK;
			res.frame_flags    = 8'h00;
			res.frame_msg_id   = 16'h0;
			res.payload_length = 16'h0;
			res.sequence_no    = 32'h0;
			res.correlation_no = 32'h0;
			res.last_of_run    = !head.has_sum;
		end else begin
			res.kind           = KIND_SUMMARY;
			res.data_byte      = 8'h00;
			res.status         = head.status;
			res.frame_flags    = head.flags;
			res.frame_msg_id   = head.msg_id;
			res.payload_length = head.length;
			res.sequence_no    = head.sequence_no;
			res.correlation_no = head.correlation_no;
			res.last_of_run    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QAW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QAW'(1);
			end
			cnt_q <= cnt_q + {{QAW{1'b0}}, push} - {{QAW{1'b0}}, pop};
			if (fire) begin
				phase_q <= byte_phase && head.has_sum;
			end
		end
	end

endmodule

### rtl/crc_checked_frame_decoder_core.sv
// Top level of the CRC-checked frame decoder: config registers, parser and result queue.
//
// Usage:
//   frame  - sink channel, one frame byte per beat; end_of_frame marks the last byte.
//   result - source channel. Bytes from index 20 on come out as payload beats
//            (kind 0); the last byte of a frame also yields a summary beat
//            (kind 1) with the header fields and the status. last_of_run marks
//            the final result beat caused by one input beat.
//   cfg_we / cfg_index / cfg_data - register writes, taken at any clock edge
//            with cfg_we high; write only while no frame byte is in flight.
// The input beat is registered in the parser (v_s1), then written into the result
//   queue; result.valid is set from the queue count.
// Throughput: one input beat per cycle while frame.ready is high; one result beat per
//   cycle while result.ready is high, so a final byte with payload needs two beats.
// A four-entry result queue decouples the sides: frame.ready drops when the
//   queue cannot absorb one more entry, so a stalled receiver stalls input
//   after a few beats and nothing is lost.
// Reset clears the per-frame state, the queue and loads the default config.
module crc_checked_frame_decoder_core #(
	parameter logic [7:0] MAX_FRAME_BYTES = crcfd_pkg::MAX_FRAME_LEN
) (
	input  logic         clk,
	input  logic         arst_n,
	crcfd_in_if.sink     frame,
	crcfd_out_if.source  result,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_data
);
	import crcfd_pkg::*;

	cfg_t         cfg_q;
	logic         take;
	logic         busy;
	logic         push;
	ent_t         ent;
	res_t         res;
	logic [QAW:0] level;

	assign frame.ready = (level + {{QAW{1'b0}}, busy}) <= QLIMIT;
	assign take        = frame.valid && frame.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic         <= RST_MAGIC;
			cfg_q.version       <= RST_VERSION;
			cfg_q.reliable_mask <= RST_RELIABLE;
			cfg_q.ack_mask      <= RST_ACK;
			cfg_q.ack_msg_id    <= RST_ACK_ID;
			cfg_q.max_payload   <= RST_MAX_PAYLOAD;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MAGIC:       cfg_q.magic         <= cfg_data;
				CFG_VERSION:     cfg_q.version       <= cfg_data[7:0];
				CFG_RELIABLE:    cfg_q.reliable_mask <= cfg_data[7:0];
				CFG_ACK:         cfg_q.ack_mask      <= cfg_data[7:0];
				CFG_ACK_ID:      cfg_q.ack_msg_id    <= cfg_data;
				CFG_MAX_PAYLOAD: cfg_q.max_payload   <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	crcfd_parse #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.take      (take),
		.take_byte (frame.rx_byte),
		.take_eof  (frame.end_of_frame),
		.busy      (busy),
		.push      (push),
		.ent       (ent)
	);

	crcfd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.ent       (ent),
		.res_ready (result.ready),
		.res_valid (result.valid),
		.res       (res),
		.level     (level)
	);

	assign result.kind           = res.kind;
	assign result.data_byte      = res.data_byte;
	assign result.status         = res.status;
	assign result.frame_flags    = res.frame_flags;
	assign result.frame_msg_id   = res.frame_msg_id;
	assign result.payload_length = res.payload_length;
	assign result.sequence_no    = res.sequence_no;
	assign result.correlation_no = res.correlation_no;
	assign result.last_of_run    = res.last_of_run;

endmodule

### test/tb.sv
// Testbench for the CRC-checked frame decoder: directed and random frames against a predictor.
module tb;
	import crcfd_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_BYTES  = 20;
	localparam int NUM_PHASES   = 6;
	localparam int SETTLE_TICKS = 8;

	typedef enum int {
		FL_NONE, FL_MAGIC, FL_VERSION, FL_FLAGS, FL_LEN_FIELD, FL_OVER_MAX, FL_CRC,
		FL_ACK_OK, FL_ACK_ID, FL_ACK_LEN, FL_ACK_REL, FL_ACK_CORR,
		FL_SHORT, FL_LONG, FL_NOISE
	} flaw_t;

	typedef enum int {
		FILL_RANDOM, FILL_ZERO, FILL_ONES
	} fill_t;

	class decoded_result_board;
		cfg_t        regs;
		logic [7:0]  byte_idx;
		logic [31:0] crc_acc;
		logic [15:0] magic_rx, msg_id_rx, length_rx;
		logic [7:0]  version_rx, flags_rx;
		logic [31:0] seq_rx, corr_rx, crc_rx;
		res_t        pending_results[$];
		int          errors;

		function new();
			regs = '{magic: RST_MAGIC, version: RST_VERSION, reliable_mask: RST_RELIABLE,
				ack_mask: RST_ACK, ack_msg_id: RST_ACK_ID, max_payload: RST_MAX_PAYLOAD};
			errors = 0;
			clear_frame();
		endfunction

		function void clear_frame();
			byte_idx = '0;
			crc_acc = CRC_INIT;
			magic_rx = '0;
			msg_id_rx = '0;
			length_rx = '0;
			version_rx = '0;
			flags_rx = '0;
			seq_rx = '0;
			corr_rx = '0;
			crc_rx = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [15:0] v);
			case (idx)
			CFG_MAGIC:       regs.magic = v;
			CFG_VERSION:     regs.version = v[7:0];
			CFG_RELIABLE:    regs.reliable_mask = v[7:0];
			CFG_ACK:         regs.ack_mask = v[7:0];
			CFG_ACK_ID:      regs.ack_msg_id = v;
			CFG_MAX_PAYLOAD: regs.max_payload = v[7:0];
			default: ;
			endcase
		endfunction

		// bit-serial reflected CRC-32, one data bit per shift
		function logic [31:0] crc32_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c;
			for (int i = 0; i < 8; i++) begin
				if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
				else r = r >> 1;
			end
			return r;
		endfunction

		function void take_byte(logic [7:0] b, logic eof);
			res_t    r;
			status_t st;
			int      sz;
			logic    ack;
			if (byte_idx < 2) magic_rx[8 * int'(byte_idx[0]) +: 8] = b;
			else if (byte_idx == 2) version_rx = b;
			else if (byte_idx == 3) flags_rx = b;
			else if (byte_idx < 6) msg_id_rx[8 * int'(byte_idx[0]) +: 8] = b;
			else if (byte_idx < 8) length_rx[8 * int'(byte_idx[0]) +: 8] = b;
			else if (byte_idx < 12) seq_rx[8 * int'(byte_idx[1:0]) +: 8] = b;
			else if (byte_idx < 16) corr_rx[8 * int'(byte_idx[1:0]) +: 8] = b;
			else if (byte_idx < HDR_LEN) crc_rx[8 * int'(byte_idx[1:0]) +: 8] = b;

			if (byte_idx < CRC_COVER_LEN || byte_idx >= HDR_LEN)
				crc_acc = crc32_step(crc_acc, b);

			if (byte_idx >= HDR_LEN) begin
				r = '0;
				r.kind = KIND_DATA;
				r.data_byte = b;
				r.last_of_run = !eof;
				pending_results.push_back(r);
			end
			if (byte_idx != CNT_SAT) byte_idx++;

			if (eof) begin
				sz = int'(byte_idx);
				ack = |(flags_rx & regs.ack_mask);
				if (sz < int'(HDR_LEN) || sz > int'(MAX_FRAME_LEN)) st = ST_LENGTH;
				else if (magic_rx != regs.magic) st = ST_MAGIC;
				else if (version_rx != regs.version) st = ST_VERSION;
				else if ((flags_rx & ~(regs.reliable_mask | regs.ack_mask)) != 0) st = ST_FLAGS;
				else if (length_rx > regs.max_payload || int'(HDR_LEN) + int'(length_rx) != sz)
					st = ST_LEN_MISMATCH;
				else if (crc_rx != ~crc_acc) st = ST_CRC;
				else if (ack && (msg_id_rx != regs.ack_msg_id || length_rx != 0 ||
						(flags_rx & regs.reliable_mask) != 0 || corr_rx == 0))
					st = ST_ACK_RULE;
				else st = ST_OK;
				r = '0;
				r.kind = KIND_SUMMARY;
				r.status = st;
				r.frame_flags = flags_rx;
				r.frame_msg_id = msg_id_rx;
				r.payload_length = length_rx;
				r.sequence_no = seq_rx;
				r.correlation_no = corr_rx;
				r.last_of_run = 1'b1;
				pending_results.push_back(r);
				clear_frame();
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= 100)
					$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_beat(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= 100)
					$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
				return;
			end
			want = pending_results.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("data_byte", want.data_byte, got.data_byte);
			compare_field("status", want.status, got.status);
			compare_field("frame_flags", want.frame_flags, got.frame_flags);
			compare_field("frame_msg_id", want.frame_msg_id, got.frame_msg_id);
			compare_field("payload_length", want.payload_length, got.payload_length);
			compare_field("sequence_no", want.sequence_no, got.sequence_no);
			compare_field("correlation_no", want.correlation_no, got.correlation_no);
			compare_field("last_of_run", want.last_of_run, got.last_of_run);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	crcfd_in_if  frame_ch();
	crcfd_out_if result_ch();

	crc_checked_frame_decoder_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.frame     (frame_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	decoded_result_board board = new();

	logic [7:0] frame_bytes[$];
	int         stall_mode;
	int         gap_max;
	int         burst_left;
	int         sent_count;
	int         cycle_count;
	res_t       seen_beat;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && frame_ch.valid && frame_ch.ready)
			board.take_byte(frame_ch.rx_byte, frame_ch.end_of_frame);
		if (arst_n && result_ch.valid && result_ch.ready) begin
			seen_beat = {result_ch.kind, result_ch.data_byte, result_ch.status,
				result_ch.frame_flags, result_ch.frame_msg_id, result_ch.payload_length,
				result_ch.sequence_no, result_ch.correlation_no, result_ch.last_of_run};
			board.check_beat(seen_beat);
		end
	end

	// receiver: free-running, random, or run-length stall pattern
	initial begin
		int ready_run;
		ready_run = 0;
		result_ch.ready = 1'b1;
		forever begin
			@(negedge clk);
			case (stall_mode)
			0: result_ch.ready = 1'b1;
			1: result_ch.ready = ($urandom_range(2) != 0);
			default: begin
				if (ready_run <= 0) begin
					result_ch.ready = !result_ch.ready;
					ready_run = result_ch.ready ? $urandom_range(6, 1) : $urandom_range(4, 1);
				end
				ready_run--;
			end
			endcase
		end
	end

	task automatic send_beat(logic [7:0] b, logic eof);
		if (gap_max > 0) begin
			if (burst_left == 0) begin
				frame_ch.valid = 1'b0;
				repeat ($urandom_range(gap_max, 1)) @(negedge clk);
				burst_left = $urandom_range(12, 1);
			end
			burst_left--;
		end
		frame_ch.valid = 1'b1;
		frame_ch.rx_byte = b;
		frame_ch.end_of_frame = eof;
		do @(posedge clk); while (!frame_ch.ready);
		@(negedge clk);
		frame_ch.valid = 1'b0;
		sent_count++;
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
	endtask

	task automatic drain();
		while (board.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] v);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		board.set_reg(idx, v);
	endtask

	task automatic load_config(logic [15:0] magic, logic [7:0] version, logic [7:0] rel,
			logic [7:0] ack, logic [15:0] ack_id, logic [7:0] max_pl);
		write_reg(CFG_MAGIC, magic);
		write_reg(CFG_VERSION, {8'h00, version});
		write_reg(CFG_RELIABLE, {8'h00, rel});
		write_reg(CFG_ACK, {8'h00, ack});
		write_reg(CFG_ACK_ID, ack_id);
		write_reg(CFG_MAX_PAYLOAD, {8'h00, max_pl});
	endtask

	// for FL_LONG, plen is the payload byte count; the length field is random
	function automatic void build_frame(flaw_t flaw, int plen, fill_t fill);
		logic [15:0] magic, msg_id, len_field;
		logic [7:0]  version, flags, spare, fill_byte;
		logic [31:0] seq, corr, crc;
		logic [7:0]  payload[$];
		int          total;
		cfg_t        c;
		c = board.regs;
		frame_bytes = {};
		if (flaw == FL_NOISE) begin
			total = $urandom_range(40, 1);
			repeat (total) frame_bytes.push_back(8'($urandom));
			return;
		end
		magic = c.magic;
		version = c.version;
		flags = 8'($urandom) & c.reliable_mask & ~c.ack_mask;
		msg_id = 16'($urandom);
		len_field = 16'(plen);
		seq = $urandom;
		corr = $urandom;
		if (flaw >= FL_ACK_OK && flaw <= FL_ACK_CORR) begin
			flags = c.ack_mask & 8'($urandom);
			if (flags == 0) flags = c.ack_mask;
			msg_id = c.ack_msg_id;
			plen = 0;
			len_field = '0;
			if (corr == 0) corr = 1;
		end
		case (flaw)
		FL_MAGIC:     magic ^= 16'($urandom_range(65535, 1));
		FL_VERSION:   version ^= 8'($urandom_range(255, 1));
		FL_FLAGS: begin
			spare = ~(c.reliable_mask | c.ack_mask);
			flags |= spare & 8'($urandom);
			if ((flags & spare) == 0) flags |= spare;
		end
		FL_LEN_FIELD: len_field ^= 16'($urandom_range(65535, 1));
		FL_OVER_MAX: begin
			if (c.max_payload < 230) begin
				plen = $urandom_range(230, int'(c.max_payload) + 1);
				len_field = 16'(plen);
			end
		end
		FL_ACK_ID:    msg_id ^= 16'($urandom_range(65535, 1));
		FL_ACK_LEN: begin
			plen = $urandom_range(4, 1);
			len_field = 16'(plen);
		end
		FL_ACK_REL:   flags |= c.reliable_mask;
		FL_ACK_CORR:  corr = '0;
		FL_LONG:      len_field = 16'($urandom);
		default: ;
		endcase

		frame_bytes = {magic[7:0], magic[15:8], version, flags, msg_id[7:0], msg_id[15:8],
			len_field[7:0], len_field[15:8], seq[7:0], seq[15:8], seq[23:16], seq[31:24],
			corr[7:0], corr[15:8], corr[23:16], corr[31:24]};
		crc = CRC_INIT;
		foreach (frame_bytes[i]) crc = board.crc32_step(crc, frame_bytes[i]);
		fill_byte = (fill == FILL_ONES) ? 8'hFF : 8'h00;
		repeat (plen) payload.push_back(fill == FILL_RANDOM ? 8'($urandom) : fill_byte);
		foreach (payload[i]) crc = board.crc32_step(crc, payload[i]);
		crc = ~crc;
		if (flaw == FL_CRC) crc ^= $urandom_range(32'hFFFF_FFFF, 1);
		frame_bytes = {frame_bytes, crc[7:0], crc[15:8], crc[23:16], crc[31:24], payload};
		if (flaw == FL_SHORT) begin
			total = $urandom_range(19, 1);
			while (frame_bytes.size() > total) void'(frame_bytes.pop_back());
		end
	endfunction

	task automatic random_frame();
		int    pick, plen, cap;
		flaw_t flaw;
		pick = $urandom_range(99);
		if (pick < 45) flaw = FL_NONE;
		else if (pick < 55) flaw = FL_ACK_OK;
		else if (pick < 58) flaw = FL_MAGIC;
		else if (pick < 61) flaw = FL_VERSION;
		else if (pick < 64) flaw = FL_FLAGS;
		else if (pick < 67) flaw = FL_LEN_FIELD;
		else if (pick < 69) flaw = FL_OVER_MAX;
		else if (pick < 74) flaw = FL_CRC;
		else if (pick < 76) flaw = FL_ACK_ID;
		else if (pick < 78) flaw = FL_ACK_LEN;
		else if (pick < 80) flaw = FL_ACK_REL;
		else if (pick < 82) flaw = FL_ACK_CORR;
		else if (pick < 89) flaw = FL_SHORT;
		else if (pick < 91) flaw = FL_LONG;
		else flaw = FL_NOISE;
		cap = int'(board.regs.max_payload);
		if ($urandom_range(9) != 0 && cap > 16) cap = 16;
		plen = (flaw == FL_LONG) ? $urandom_range(280, 231) : $urandom_range(cap, 0);
		build_frame(flaw, plen, FILL_RANDOM);
		send_frame();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAGIC;
		cfg_data = '0;
		frame_ch.valid = 1'b0;
		frame_ch.rx_byte = '0;
		frame_ch.end_of_frame = 1'b0;
		stall_mode = 0;
		gap_max = 0;
		burst_left = 0;
		sent_count = 0;
		cycle_count = 0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset configuration first
		build_frame(FL_NONE, 2, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_OK, 0, FILL_RANDOM);
		send_frame();
		drain();

		load_config(16'hA55A, 8'd3, 8'h01, 8'h02, 16'h1234, 8'd200);
		stall_mode = 1;
		gap_max = 3;
		build_frame(FL_NONE, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_NONE, 4, FILL_ZERO);
		send_frame();
		build_frame(FL_NONE, 4, FILL_ONES);
		send_frame();
		build_frame(FL_NONE, 200, FILL_RANDOM);
		send_frame();
		// payload over the limit but consistent with frame size
		build_frame(FL_OVER_MAX, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_MAGIC, 3, FILL_RANDOM);
		send_frame();
		build_frame(FL_VERSION, 3, FILL_RANDOM);
		send_frame();
		build_frame(FL_FLAGS, 3, FILL_RANDOM);
		send_frame();
		build_frame(FL_LEN_FIELD, 3, FILL_RANDOM);
		send_frame();
		build_frame(FL_CRC, 3, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_OK, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_ID, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_LEN, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_REL, 0, FILL_RANDOM);
		send_frame();
		build_frame(FL_ACK_CORR, 0, FILL_RANDOM);
		send_frame();
		// single-byte frame and one byte short of a header
		build_frame(FL_NONE, 0, FILL_RANDOM);
		frame_bytes = frame_bytes[0:0];
		send_frame();
		build_frame(FL_NONE, 0, FILL_RANDOM);
		frame_bytes = frame_bytes[0:18];
		send_frame();
		// one byte past the frame limit, then long enough to saturate the count
		build_frame(FL_LONG, 231, FILL_RANDOM);
		send_frame();
		build_frame(FL_LONG, 280, FILL_RANDOM);
		send_frame();
		drain();

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
			0: load_config(16'h0000, 8'd0, 8'h00, 8'h00, 16'h0000, 8'd0);
			1: load_config(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'd230);
			2: load_config(16'hFFFF, 8'hFF, 8'hF0, 8'h0F, 16'hFFFF, 8'd230);
			3: load_config(16'h0001, 8'd1, 8'h80, 8'h01, 16'h0000, 8'd1);
			default: load_config(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
				16'($urandom), 8'($urandom_range(230)));
			endcase
			if (ph == 2) begin
				stall_mode = 0;
				gap_max = 0;
			end else begin
				stall_mode = $urandom_range(2);
				gap_max = $urandom_range(1) ? $urandom_range(8, 1) : 0;
			end
			burst_left = 0;
			sent_count = 0;
			while (sent_count < PHASE_BYTES) begin
				random_frame();
				if ($urandom_range(19) == 0) drain();
			end
			drain();
		end

		if (board.errors == 0 && board.pending_results.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
